// File: rtl/fsad_pkg.sv
// Shared constants for the fiber stress pipeline.
package fsad_pkg;

  // Configuration register indexes
  localparam logic CFG_DIR_COSINE = 1'b0;
  localparam logic CFG_DIR_SINE   = 1'b1;

  // Reset values of the direction registers (Q1.14)
  localparam logic [15:0] DIR_COSINE_RST = 16'd16384;
  localparam logic [15:0] DIR_SINE_RST   = 16'd0;

  // Field widths
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned TAG_W   = 20;
  localparam int unsigned OUT_W   = 32;

  // Unit latencies
  localparam int unsigned DIV_LAT = 25;  // init stage plus one quotient bit per stage
  localparam int unsigned EXP_LAT = 37;  // 26 series stages plus 11 power stages

  // Q.30 one and rounding half
  localparam logic [30:0] ONE30  = 31'h4000_0000;
  localparam logic [29:0] HALF29 = 30'h2000_0000;

  // exp(-1) in Q.30 as the truncated series gives it
  localparam logic [28:0] EXP_M1 = 29'd395007543;

  // ceil(2^34 / k) for the series divisions
  localparam logic [34:0] EXP_RECIP [1:13] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
    35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
    35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766,
    35'd1321528399
  };

  // ceil(2^30 / 9): exact quotient for values below 2^26
  localparam logic [26:0] RECIP9   = 27'd119304648;
  // ceil(2^50 / 289): exact quotient for values below 2^41
  localparam logic [41:0] RECIP289 = 42'd3895847428522;
  // quadratic term reaches 2^32 at this scaled square
  localparam logic [41:0] QUAD_LIM = 42'd1241245548544;

endpackage

// File: rtl/fsad_div.sv
// Pipelined restoring divider: saturated floor(4 * mag / adet), one bit per stage.
module fsad_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [62:0] mag_i,
  input  logic [47:0] adet_i,
  output logic [24:0] quo_o
);

  localparam int unsigned STEPS = fsad_pkg::DIV_LAT - 1;

  logic [47:0] rem_q  [0:STEPS];
  logic [23:0] low_q  [0:STEPS];
  logic [23:0] quo_q  [0:STEPS];
  logic [47:0] adet_q [0:STEPS];
  logic        sat_q  [0:STEPS];
  logic [48:0] r2_c   [1:STEPS];
  logic        ge_c   [1:STEPS];

  // trial subtract of each step
  always_comb begin
    for (int s = 1; s <= STEPS; s++) begin
      r2_c[s] = {rem_q[s-1], low_q[s-1][23]};
      ge_c[s] = r2_c[s] >= {1'b0, adet_q[s-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // upper part of 4*mag; quotient overflows 24 bits when it reaches the divisor
      rem_q[0]  <= {7'd0, mag_i[62:22]};
      low_q[0]  <= {mag_i[21:0], 2'b00};
      quo_q[0]  <= '0;
      adet_q[0] <= adet_i;
      sat_q[0]  <= {7'd0, mag_i[62:22]} >= adet_i;
      for (int s = 1; s <= STEPS; s++) begin
        rem_q[s]  <= ge_c[s] ? 48'(r2_c[s] - {1'b0, adet_q[s-1]}) : r2_c[s][47:0];
        low_q[s]  <= {low_q[s-1][22:0], 1'b0};
        quo_q[s]  <= {quo_q[s-1][22:0], ge_c[s]};
        adet_q[s] <= adet_q[s-1];
        sat_q[s]  <= sat_q[s-1];
      end
    end
  end

  assign quo_o = sat_q[STEPS] ? 25'h100_0000 : {1'b0, quo_q[STEPS]};

endmodule

// File: rtl/fsad_exp.sv
// Pipelined exp(-(n + f)): 13-term series of exp(-f), then n multiplies by exp(-1), Q.30.
module fsad_exp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] f_i,
  input  logic [3:0]  n_i,
  output logic [30:0] acc_o
);

  localparam int unsigned SER_ST = 26;
  localparam int unsigned LAST   = fsad_pkg::EXP_LAT;

  logic [29:0] f_q    [1:SER_ST];
  logic [30:0] term_q [1:SER_ST];
  logic [30:0] sum_q  [1:LAST];
  logic [3:0]  n_q    [1:LAST];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // first product: 1.0 * f
      f_q[1]    <= f_i;
      term_q[1] <= {1'b0, f_i};
      sum_q[1]  <= fsad_pkg::ONE30;
      n_q[1]    <= n_i;
      // series: odd stages multiply by f, even stages divide by k and accumulate
      for (int s = 2; s <= SER_ST; s++) begin
        f_q[s] <= f_q[s-1];
        n_q[s] <= n_q[s-1];
        if (s % 2 == 1) begin
          term_q[s] <= 31'((61'(term_q[s-1]) * 61'(f_q[s-1])) >> 30);
          sum_q[s]  <= sum_q[s-1];
        end else begin
          term_q[s] <= 31'((66'(term_q[s-1]) * 66'(fsad_pkg::EXP_RECIP[s/2])) >> 34);
          if ((s / 2) % 2 == 1) begin
            sum_q[s] <= sum_q[s-1] -
                        31'((66'(term_q[s-1]) * 66'(fsad_pkg::EXP_RECIP[s/2])) >> 34);
          end else begin
            sum_q[s] <= sum_q[s-1] +
                        31'((66'(term_q[s-1]) * 66'(fsad_pkg::EXP_RECIP[s/2])) >> 34);
          end
        end
      end
      // integer part: one rounded multiply by exp(-1) per stage while count allows
      for (int s = SER_ST + 1; s <= LAST; s++) begin
        n_q[s] <= n_q[s-1];
        if (n_q[s-1] > 4'(s - SER_ST - 1)) begin
          sum_q[s] <= 31'((62'(sum_q[s-1]) * 62'(fsad_pkg::EXP_M1) +
                           62'(fsad_pkg::HALF29)) >> 30);
        end else begin
          sum_q[s] <= sum_q[s-1];
        end
      end
    end
  end

  assign acc_o = sum_q[LAST];

endmodule

// File: rtl/fiber_stress_along_direction_top.sv
// Fiber stress along a configured direction: top level pipeline.
//
// One triangle request is taken per clock while the output is not stalled. The latency is
// set by the 25-stage gradient divider and the 37-stage exponential unit, with twelve
// arithmetic stages around them. A stall on the output freezes the whole pipeline and is
// passed straight back to the input. The direction registers are plain writes and should
// change only while the pipeline is empty.
module fiber_stress_along_direction_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] def_edge1_x_i,
  input  logic signed [23:0] def_edge1_y_i,
  input  logic signed [23:0] def_edge2_x_i,
  input  logic signed [23:0] def_edge2_y_i,
  input  logic signed [23:0] rest_edge1_x_i,
  input  logic signed [23:0] rest_edge1_y_i,
  input  logic signed [23:0] rest_edge2_x_i,
  input  logic signed [23:0] rest_edge2_y_i,
  input  logic [19:0]        face_tag_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        stress_value_o,
  output logic               degenerate_rest_o,
  output logic [19:0]        result_tag_o
);

  // stage indexes
  localparam int unsigned IP5  = 5;
  localparam int unsigned IDIV = IP5 + fsad_pkg::DIV_LAT;
  localparam int unsigned IX3  = IDIV + 3;
  localparam int unsigned IX4  = IDIV + 4;
  localparam int unsigned IX6  = IDIV + 6;
  localparam int unsigned IX7  = IX6 + 1;
  localparam int unsigned IEXP = IX6 + fsad_pkg::EXP_LAT;
  localparam int unsigned IOUT = IEXP + 1;

  logic en;

  logic signed [15:0] cos_q, sin_q;

  logic                      vld_q [1:IOUT];
  logic [fsad_pkg::TAG_W-1:0] tag_q [1:IOUT];
  logic                      degen_q [3:IOUT];

  // front stages
  logic signed [47:0] ad_q, bc_q;
  logic signed [39:0] dux_q, buy_q, auy_q, cux_q;
  logic signed [23:0] p_q [1:2];
  logic signed [23:0] pc_q [1:2];
  logic signed [23:0] qv_q [1:2];
  logic signed [23:0] qc_q [1:2];
  logic signed [48:0] det_q;
  logic signed [39:0] w0_q, w1_q;
  logic signed [43:0] pw0h_q, pcw0h_q, qw1h_q, qcw1h_q;
  logic signed [44:0] pw0l_q, pcw0l_q, qw1l_q, qcw1l_q;
  logic [47:0]        adet_q [3:5];
  logic signed [63:0] v0_q, v1_q;
  logic [62:0]        mag0_q, mag1_q;

  // back stages
  logic [24:0] quo0, quo1;
  logic [48:0] sq0_q, sq1_q;
  logic [49:0] s_q;
  logic [32:0] m_q;
  logic        pos_q   [IX3:IEXP];
  logic        qsat_q  [IX4:IEXP];
  logic        expok_q [IX4:IX6];
  logic [43:0] mq_q;
  logic [25:0] t_q;
  logic [41:0] t2_q;
  logic [22:0] y_q;
  logic        qbig_q  [IX6:IEXP];
  logic [41:0] pll_q, plh_q;
  logic [40:0] phl_q, phh_q;
  logic        expz_q  [IX7:IEXP];
  logic [31:0] quad_q  [IX7:IEXP];
  logic [30:0] acc;
  logic [83:0] quad_sum;

  logic [16:0] ex_r;
  logic [31:0] quad_use;
  logic [32:0] total;
  logic        sat;
  logic [31:0] stress_d, stress_q;

  // global advance: hold everything while a result waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // direction registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= fsad_pkg::DIR_COSINE_RST;
      sin_q <= fsad_pkg::DIR_SINE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fsad_pkg::CFG_DIR_COSINE: cos_q <= cfg_data_i;
        fsad_pkg::CFG_DIR_SINE:   sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= IOUT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int i = 2; i <= IOUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // gradient numerators and rest determinant
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[1] <= face_tag_i;
      for (int i = 2; i <= IOUT; i++) tag_q[i] <= tag_q[i-1];

      // P1: products of rest edges
      ad_q  <= rest_edge1_x_i * rest_edge2_y_i;
      bc_q  <= rest_edge2_x_i * rest_edge1_y_i;
      dux_q <= rest_edge2_y_i * cos_q;
      buy_q <= rest_edge2_x_i * sin_q;
      auy_q <= rest_edge1_x_i * sin_q;
      cux_q <= rest_edge1_y_i * cos_q;
      p_q[1]  <= def_edge1_x_i;
      pc_q[1] <= def_edge1_y_i;
      qv_q[1] <= def_edge2_x_i;
      qc_q[1] <= def_edge2_y_i;

      // P2: determinant and adj(R) * u
      det_q   <= ad_q - bc_q;
      w0_q    <= dux_q - buy_q;
      w1_q    <= auy_q - cux_q;
      p_q[2]  <= p_q[1];
      pc_q[2] <= pc_q[1];
      qv_q[2] <= qv_q[1];
      qc_q[2] <= qc_q[1];

      // P3: split products D * w
      pw0h_q  <= p_q[2]  * $signed(w0_q[39:20]);
      pw0l_q  <= p_q[2]  * $signed({1'b0, w0_q[19:0]});
      pcw0h_q <= pc_q[2] * $signed(w0_q[39:20]);
      pcw0l_q <= pc_q[2] * $signed({1'b0, w0_q[19:0]});
      qw1h_q  <= qv_q[2] * $signed(w1_q[39:20]);
      qw1l_q  <= qv_q[2] * $signed({1'b0, w1_q[19:0]});
      qcw1h_q <= qc_q[2] * $signed(w1_q[39:20]);
      qcw1l_q <= qc_q[2] * $signed({1'b0, w1_q[19:0]});
      adet_q[3] <= det_q[48] ? 48'(-det_q) : det_q[47:0];
      degen_q[3] <= (det_q == '0);
      for (int i = 4; i <= IOUT; i++) degen_q[i] <= degen_q[i-1];

      // P4: sum partials
      v0_q <= (pw0h_q <<< 20) + pw0l_q + (qw1h_q <<< 20) + qw1l_q;
      v1_q <= (pcw0h_q <<< 20) + pcw0l_q + (qcw1h_q <<< 20) + qcw1l_q;
      adet_q[4] <= adet_q[3];

      // P5: magnitudes
      mag0_q <= v0_q[63] ? 63'(-v0_q) : v0_q[62:0];
      mag1_q <= v1_q[63] ? 63'(-v1_q) : v1_q[62:0];
      adet_q[5] <= adet_q[4];
    end
  end

  // |Fu| components in Q.16
  fsad_div u_div0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag0_q),
    .adet_i (adet_q[IP5]),
    .quo_o  (quo0)
  );

  fsad_div u_div1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag1_q),
    .adet_i (adet_q[IP5]),
    .quo_o  (quo1)
  );

  // strain and the arguments of both stress terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      // X1, X2: squared length
      sq0_q <= quo0 * quo0;
      sq1_q <= quo1 * quo1;
      s_q   <= sq0_q + sq1_q;

      // X3: strain sign and magnitude in Q.16
      pos_q[IX3] <= s_q > 50'h1_0000_0000;
      m_q <= 33'((s_q > 50'h1_0000_0000 ? s_q - 50'h1_0000_0000
                                         : 50'h1_0000_0000 - s_q) >> 17);

      // X4: square of the magnitude
      mq_q          <= m_q[21:0] * m_q[21:0];
      expok_q[IX4]  <= m_q < 33'h1_0000;
      qsat_q[IX4]   <= pos_q[IX3] && (m_q >= 33'h40_0000);
      for (int i = IX3 + 1; i <= IEXP; i++) pos_q[i] <= pos_q[i-1];
      for (int i = IX4 + 1; i <= IEXP; i++) qsat_q[i] <= qsat_q[i-1];
      for (int i = IX4 + 1; i <= IX6; i++) expok_q[i] <= expok_q[i-1];

      // X5: constant scaling
      t_q  <= 26'((42'(mq_q[31:0]) * 42'd625) >> 16);
      t2_q <= 42'((58'(mq_q) * 58'd10000) >> 16);

      // X6: divide by 9 and split the divide by 289
      y_q    <= 23'((53'(t_q) * 53'(fsad_pkg::RECIP9)) >> 30);
      qbig_q[IX6] <= t2_q >= fsad_pkg::QUAD_LIM;
      pll_q  <= t2_q[20:0]  * fsad_pkg::RECIP289[20:0];
      plh_q  <= t2_q[20:0]  * fsad_pkg::RECIP289[41:21];
      phl_q  <= 41'(t2_q[40:21] * fsad_pkg::RECIP289[20:0]);
      phh_q  <= 41'(t2_q[40:21] * fsad_pkg::RECIP289[41:21]);
      for (int i = IX6 + 1; i <= IEXP; i++) qbig_q[i] <= qbig_q[i-1];

      // X7: quadratic term and exponent range
      quad_q[IX7] <= quad_sum[81:50];
      expz_q[IX7] <= !expok_q[IX6] || (y_q[22:16] >= 7'd12);
      for (int i = IX7 + 1; i <= IEXP; i++) begin
        quad_q[i] <= quad_q[i-1];
        expz_q[i] <= expz_q[i-1];
      end

      stress_q <= stress_d;
    end
  end

  assign quad_sum = 84'(pll_q) + ((84'(plh_q) + 84'(phl_q)) << 21) + (84'(phh_q) << 42);

  // exponential term
  fsad_exp u_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   ({y_q[15:0], 14'd0}),
    .n_i   (y_q[19:16]),
    .acc_o (acc)
  );

  // final sum with saturation
  always_comb begin
    ex_r     = expz_q[IEXP] ? '0 : 17'((32'(acc) + 32'h2000) >> 14);
    quad_use = (pos_q[IEXP] && !qsat_q[IEXP] && !qbig_q[IEXP]) ? quad_q[IEXP] : '0;
    total    = 33'(ex_r) + 33'(quad_use);
    sat      = (pos_q[IEXP] && (qsat_q[IEXP] || qbig_q[IEXP])) || total[32];
    if (degen_q[IEXP]) begin
      stress_d = '0;
    end else if (sat) begin
      stress_d = '1;
    end else begin
      stress_d = total[31:0];
    end
  end

  assign out_valid_o       = vld_q[IOUT];
  assign stress_value_o    = stress_q;
  assign degenerate_rest_o = degen_q[IOUT];
  assign result_tag_o      = tag_q[IOUT];

endmodule

// File: rtl/fsad_check.sv
// Port-level checks for the fiber stress pipeline, bound to the top level.
module fsad_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] stress_value_o,
  input logic        degenerate_rest_o,
  input logic [19:0] result_tag_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(stress_value_o) && $stable(result_tag_o) &&
                                   $stable(degenerate_rest_o))
    else $error("result changed while stalled");

  // degenerate rest triangle gives zero stress
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_rest_o |-> stress_value_o == 32'd0)
    else $error("degenerate triangle with nonzero stress");

  // input stalls only while a result waits
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

endmodule

bind fiber_stress_along_direction_top fsad_check u_fsad_check (.*);

// File: tb/fsad_checker.sv
// Checker for the fiber stress pipeline: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module fsad_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [23:0] def_edge1_x_i,
  input  logic signed [23:0] def_edge1_y_i,
  input  logic signed [23:0] def_edge2_x_i,
  input  logic signed [23:0] def_edge2_y_i,
  input  logic signed [23:0] rest_edge1_x_i,
  input  logic signed [23:0] rest_edge1_y_i,
  input  logic signed [23:0] rest_edge2_x_i,
  input  logic signed [23:0] rest_edge2_y_i,
  input  logic [19:0]        face_tag_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        stress_value_i,
  input  logic               degenerate_rest_i,
  input  logic [19:0]        result_tag_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] stress;
    logic        degen;
    logic [19:0] tag;
  } stress_res_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  logic [15:0] dir_cos_q;
  logic [15:0] dir_sin_q;
  stress_res_t stress_q [$];
  int          mismatches;

  // exp(-f) by truncated series, f and result in Q.30
  function automatic logic [63:0] exp_series(input logic [63:0] f30);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f30) >> 30) / k;
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return sum;
  endfunction

  // |Fu component| in Q.16, clamped at 256.0
  function automatic logic [63:0] grad_mag(input logic [63:0] num, input logic [63:0] adet);
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] rem;
    mag = num[63] ? (64'd0 - num) : num;
    quo = mag / adet;
    rem = mag % adet;
    if (quo >= (64'd1 << 22)) return 64'd1 << 24;
    return (quo << 2) + ((rem << 2) / adet);
  endfunction

  // Expected stress of one triangle under the current direction
  function automatic stress_res_t predict_stress(
    input logic signed [23:0] dx1, input logic signed [23:0] dy1,
    input logic signed [23:0] dx2, input logic signed [23:0] dy2,
    input logic signed [23:0] rx1, input logic signed [23:0] ry1,
    input logic signed [23:0] rx2, input logic signed [23:0] ry2,
    input logic [19:0] tag, input logic [15:0] cos_q, input logic [15:0] sin_q);
    stress_res_t res;
    longint      ux, uy, det, w0, w1;
    logic [63:0] adet, v0, v1, f0, f1, s, m, y, n, acc, e1, ex, quad, tot;
    logic        pos, sat;
    res.tag   = tag;
    res.degen = 1'b0;
    res.stress = '0;
    ux  = longint'($signed(cos_q));
    uy  = longint'($signed(sin_q));
    det = longint'(rx1) * longint'(ry2) - longint'(rx2) * longint'(ry1);
    if (det == 0) begin
      res.degen = 1'b1;
      return res;
    end
    adet = (det < 0) ? 64'(-det) : 64'(det);
    w0 = longint'(ry2) * ux - longint'(rx2) * uy;
    w1 = longint'(rx1) * uy - longint'(ry1) * ux;
    v0 = 64'(longint'(dx1) * w0) + 64'(longint'(dx2) * w1);
    v1 = 64'(longint'(dy1) * w0) + 64'(longint'(dy2) * w1);
    f0 = grad_mag(v0, adet);
    f1 = grad_mag(v1, adet);
    s   = f0 * f0 + f1 * f1;
    pos = s > (64'd1 << 32);
    m   = (pos ? s - (64'd1 << 32) : (64'd1 << 32) - s) >> 17;
    ex = '0;
    quad = '0;
    sat = 1'b0;
    // exponential term, whole part by repeated exp(-1)
    if (m < (64'd1 << 16)) begin
      y = (m * m * 64'd625) / 64'd589824;
      n = y >> 16;
      if (n < 12) begin
        e1  = exp_series(Q30_ONE);
        acc = exp_series((y & 64'hFFFF) << 14);
        for (int i = 0; i < n; i++) acc = (acc * e1 + (64'd1 << 29)) >> 30;
        ex = (acc + (64'd1 << 13)) >> 14;
      end
    end
    // quadratic term under tension only
    if (pos) begin
      if (m >= (64'd1 << 22)) sat = 1'b1;
      else quad = (m * m * 64'd10000) / (64'd289 * 64'd65536);
    end
    tot = ex + quad;
    res.stress = (sat || tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
    return res;
  endfunction

  // Track registers, queue expectations, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    stress_res_t want;
    if (!rst_ni) begin
      dir_cos_q  <= fsad_pkg::DIR_COSINE_RST;
      dir_sin_q  <= fsad_pkg::DIR_SINE_RST;
      stress_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == fsad_pkg::CFG_DIR_COSINE) dir_cos_q <= cfg_data_i;
        else                                         dir_sin_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        stress_q.push_back(predict_stress(def_edge1_x_i, def_edge1_y_i, def_edge2_x_i,
          def_edge2_y_i, rest_edge1_x_i, rest_edge1_y_i, rest_edge2_x_i, rest_edge2_y_i,
          face_tag_i, dir_cos_q, dir_sin_q));
      if (out_valid_i && !out_stall_i) begin
        if (stress_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result tag=%h stress=%h", result_tag_i,
                     stress_value_i);
        end else begin
          want = stress_q.pop_front();
          if (want.stress !== stress_value_i || want.degen !== degenerate_rest_i ||
              want.tag !== result_tag_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected stress=%h degen=%b tag=%h, got %h %b %h",
                       want.stress, want.degen, want.tag, stress_value_i,
                       degenerate_rest_i, result_tag_i);
          end
        end
      end
      fail_count_o <= mismatches + 0;
      pending_o    <= stress_q.size();
    end
  end

endmodule

// File: tb/fiber_stress_along_direction_top_tb.sv
// Testbench top for the fiber stress pipeline: stimulus, idling and verdict.
`timescale 1ns / 1ps

module fiber_stress_along_direction_top_tb;

  typedef struct packed {
    logic signed [23:0] dx1, dy1, dx2, dy2, rx1, ry1, rx2, ry2;
    logic [19:0]        tag;
  } tri_req_t;

  localparam int IDLE_LIMIT = 5000;
  localparam int ONE_Q16    = 65536;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = fsad_pkg::CFG_DIR_COSINE;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] def_edge1_x_i = '0, def_edge1_y_i = '0;
  logic signed [23:0] def_edge2_x_i = '0, def_edge2_y_i = '0;
  logic signed [23:0] rest_edge1_x_i = '0, rest_edge1_y_i = '0;
  logic signed [23:0] rest_edge2_x_i = '0, rest_edge2_y_i = '0;
  logic [19:0]        face_tag_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        stress_value_o;
  logic               degenerate_rest_o;
  logic [19:0]        result_tag_o;
  int                 fail_count;
  int                 pending;
  int                 req_count = 0;
  int                 idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  fiber_stress_along_direction_top uut (.*);

  fsad_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .def_edge1_x_i, .def_edge1_y_i, .def_edge2_x_i, .def_edge2_y_i,
    .rest_edge1_x_i, .rest_edge1_y_i, .rest_edge2_x_i, .rest_edge2_y_i, .face_tag_i,
    .out_valid_i(out_valid_o), .out_stall_i, .stress_value_i(stress_value_o),
    .degenerate_rest_i(degenerate_rest_o), .result_tag_i(result_tag_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (in_valid_i && !in_stall_o) req_count <= req_count + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    bit held;
    bit quiet;
    int r;
    held = 0;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && req_count >= 300) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) out_stall_i <= 1'b0;
      else if (r < 95)     out_stall_i <= 1'b1;
      else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one request, sometimes with a random gap before it
  task automatic send_req(input tri_req_t t);
    int r;
    bit ok;
    r = $urandom_range(0, 99);
    if (r >= 60) begin
      in_valid_i <= 1'b0;
      repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk_i);
    end
    {def_edge1_x_i, def_edge1_y_i, def_edge2_x_i, def_edge2_y_i, rest_edge1_x_i,
     rest_edge1_y_i, rest_edge2_x_i, rest_edge2_y_i, face_tag_i} <= t;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
  endtask

  // Pause the sender until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random triangle: mostly near-identity, some degenerate, some with tiny rest edges, some raw noise
  function automatic tri_req_t rand_tri();
    tri_req_t t;
    int s, e, k, r;
    r = $urandom_range(0, 99);
    t.tag = 20'($urandom);
    if (r < 55) begin
      s = $urandom_range(16384, 262144);
      t.rx1 = 24'(s + srand(s / 8));
      t.ry1 = 24'(srand(s / 8));
      t.rx2 = 24'(srand(s / 8));
      t.ry2 = 24'(s + srand(s / 8));
      e = srand(60);
      t.dx1 = 24'(t.rx1 + t.rx1 * e / 256 + srand(64));
      t.dy1 = 24'(t.ry1 + t.ry1 * srand(60) / 256 + srand(64));
      t.dx2 = 24'(t.rx2 + t.rx2 * srand(60) / 256 + srand(64));
      t.dy2 = 24'(t.ry2 + t.ry2 * e / 256 + srand(64));
    end else begin
      {t.dx1, t.dy1, t.dx2, t.dy2} = {$urandom, $urandom, $urandom};
      {t.rx1, t.ry1, t.rx2, t.ry2} = {$urandom, $urandom, $urandom};
      if (r < 70) begin
        k = srand(3);
        t.rx1 = 24'(srand(1000000));
        t.ry1 = 24'(srand(1000000));
        t.rx2 = 24'(t.rx1 * k);
        t.ry2 = 24'(t.ry1 * k);
      end else if (r < 78) begin
        t.rx1 = 24'(srand(64));
        t.ry1 = 24'(srand(64));
        t.rx2 = 24'(srand(64));
        t.ry2 = 24'(srand(64));
      end
    end
    return t;
  endfunction

  function automatic tri_req_t mk(input int a, b, c, d, e, f, g, h, input logic [19:0] tg);
    tri_req_t t;
    t = {24'(a), 24'(b), 24'(c), 24'(d), 24'(e), 24'(f), 24'(g), 24'(h), tg};
    return t;
  endfunction

  // Main stimulus: directed checks, then random phases over direction settings
  initial begin
    logic [15:0] cos_set [6];
    logic [15:0] sin_set [6];
    tri_req_t dir_list [$];
    int ph;
    cos_set = '{16'hC000, 16'h0000, 16'd11585, 16'h8000, 16'h7FFF, 16'h0};
    sin_set = '{16'h0000, 16'h4000, 16'hD2BF, 16'h7FFF, 16'h8000, 16'h0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit rest, zero strain, stretch, compress, degenerate, huge gradient, extremes
    dir_list.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 20'h00000));
    dir_list.push_back(mk(ONE_Q16, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'hFFFFF));
    dir_list.push_back(mk(72090, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h00001));
    dir_list.push_back(mk(58982, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h00002));
    dir_list.push_back(mk(85197, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h00003));
    dir_list.push_back(mk(0, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h00004));
    dir_list.push_back(mk(131072, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h00005));
    dir_list.push_back(mk(ONE_Q16, 0, 0, ONE_Q16, 0, ONE_Q16, ONE_Q16, 0, 20'h00006));
    dir_list.push_back(mk(8388607, 8388607, 8388607, 8388607, 1, 0, 0, 1, 20'h00007));
    dir_list.push_back(mk(-8388608, -8388608, -8388608, -8388608, 1, 0, 0, 1, 20'h00008));
    dir_list.push_back(mk(8388607, -8388608, -8388608, 8388607, 8388607, -8388608,
                          -8388608, 8388607, 20'h00009));
    dir_list.push_back(mk(1, 2, 3, 4, 8388607, 8388607, 8388607, 8388607, 20'h0000A));
    dir_list.push_back(mk(-8388608, 8388607, 8388607, -8388608, -8388608, 0, 0, 8388607,
                          20'h0000B));
    dir_list.push_back(mk(ONE_Q16, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16, 2 * ONE_Q16,
                          2 * ONE_Q16, 20'h0000C));
    dir_list.push_back(mk(1048576, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h0000D));
    dir_list.push_back(mk(-ONE_Q16, 0, 0, -ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, 20'h0000E));
    dir_list.push_back(mk(ONE_Q16, 0, 0, ONE_Q16, -8388608, 0, 0, -8388608, 20'h0000F));
    foreach (dir_list[i]) send_req(dir_list[i]);
    repeat (200) send_req(rand_tri());
    drain();

    // each phase writes both registers, then runs a random batch
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        cos_set[ph] = 16'(srand(16384));
        sin_set[ph] = 16'(srand(16384));
      end
      write_reg(fsad_pkg::CFG_DIR_COSINE, cos_set[ph]);
      write_reg(fsad_pkg::CFG_DIR_SINE, sin_set[ph]);
      repeat (190) send_req(rand_tri());
      drain();
    end

    do @(negedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
